@@ sv/bbpt_pkg.sv @@
package bbpt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PARAM_W   = FRAC_BITS + 1;
  localparam int NUM_SLOTS = 16;
  localparam int ACC_W     = 56;
  localparam int PROD_W    = 32 + PARAM_W + 1;

  localparam logic [PARAM_W-1:0] ONE_Q   = PARAM_W'(1) << FRAC_BITS;
  localparam logic [16:0]        STEP_RST = 17'd16384;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [3:0]         slot;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [7:0]         cell_u;
    logic [7:0]         cell_v;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               last_vertex;
  } out_item_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic               is_emit;
    logic [3:0]         slot;
    logic [95:0]        coords;
    logic [PARAM_W-1:0] u0;
    logic [PARAM_W-1:0] u1;
    logic [PARAM_W-1:0] v0;
    logic [PARAM_W-1:0] v1;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASIS,
    ST_WGT,
    ST_PROD,
    ST_ACC,
    ST_FIN
  } back_state_t;

endpackage

@@ sv/bicubic_bezier_patch_tessellator_core.sv @@
// Bicubic Bezier patch tessellator.
// Input queue (push/full, in_item): a load item (kind 0) writes control point
// slot 0..15; an emit item (kind 1) asks for the six vertices of grid cell
// (cell_u, cell_v), two triangles, the sixth flagged by last_vertex.
// Result queue (empty/pop, out_item): the oldest vertex is shown while empty is
// low and leaves on a cycle with pop high.
// step_we/step_data writes the Q1.16 step per cell; write it only when idle.
// The front computes the cell edge parameters on accept and parks items in a
// two-entry queue; the back runs one item at a time with one shared rounding
// multiplier and a 16-entry point memory.
// Load item: written into the point memory from the idle state. Emit item: per
// vertex the basis steps, then a weight, product and accumulate step for each of
// the 16 slots, then an output step; the serial slot loop over the point memory sets the pace.
// Reset empties both queues and sets the step to 0.25; the control points are
// undefined until loaded. A stalled receiver holds the finished vertex; the
// back then waits and the front keeps taking items until its queue is full.
module bicubic_bezier_patch_tessellator_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  bbpt_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output bbpt_pkg::out_item_t out_item,
  input  logic                step_we,
  input  logic [16:0]         step_data
);
  import bbpt_pkg::*;

  logic [16:0] step_size;
  logic        job_valid;
  logic        job_pop;
  job_t        job;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_RST;
    end else if (step_we) begin
      step_size <= step_data;
    end
  end

  bbpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .step_size (step_size),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  bbpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

@@ sv/bbpt_front.sv @@
module bbpt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  bbpt_pkg::in_item_t in_item,
  input  logic [16:0]        step_size,
  output logic               job_valid,
  output bbpt_pkg::job_t     job,
  input  logic               job_pop
);
  import bbpt_pkg::*;

  job_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  job_t       new_job;
  logic [24:0] pu0;
  logic [24:0] pv0;
  logic [25:0] pu1;
  logic [25:0] pv1;

  function automatic logic [PARAM_W-1:0] sat_param(input logic [25:0] x);
    if (x > 26'(ONE_Q)) begin
      return ONE_Q;
    end
    return x[PARAM_W-1:0];
  endfunction

  always_comb begin
    pu0 = in_item.cell_u * step_size;
    pv0 = in_item.cell_v * step_size;
    pu1 = {1'b0, pu0} + 26'(step_size);
    pv1 = {1'b0, pv0} + 26'(step_size);
    new_job.is_emit = (in_item.kind == KIND_EMIT);
    new_job.slot    = in_item.slot;
    new_job.coords  = {in_item.point_z, in_item.point_y, in_item.point_x};
    new_job.u0      = sat_param({1'b0, pu0});
    new_job.u1      = sat_param(pu1);
    new_job.v0      = sat_param({1'b0, pv0});
    new_job.v1      = sat_param(pv1);
  end

  assign full      = (count == 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = job_pop && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ sv/bbpt_back.sv @@
module bbpt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  bbpt_pkg::job_t      job,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output bbpt_pkg::out_item_t out_item
);
  import bbpt_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [95:0]        coords [NUM_SLOTS];
  logic [95:0]        rd;
  logic [3:0]         slot;
  logic [3:0]         bstep;
  logic [2:0]         vk;
  logic [PARAM_W-1:0] u0, u1, v0, v1;
  logic [PARAM_W-1:0] bu [4];
  logic [PARAM_W-1:0] bv [4];
  logic [PARAM_W-1:0] t2, r2, w;
  logic signed [PROD_W-1:0] prod [3];
  logic signed [ACC_W-1:0]  acc [3];
  logic               out_valid;

  logic [PARAM_W-1:0] cur_u, cur_v, t, r, mul_a, mul_b, fx_res;
  logic [2:0]         sub;
  logic [2*PARAM_W-1:0] mul_full;
  logic [PARAM_W-1:0] b_val;

  // corner order of the two triangles
  always_comb begin
    case (vk)
      3'd0:    begin cur_u = u0; cur_v = v0; end
      3'd1:    begin cur_u = u1; cur_v = v0; end
      3'd2:    begin cur_u = u0; cur_v = v1; end
      3'd3:    begin cur_u = u0; cur_v = v1; end
      3'd4:    begin cur_u = u1; cur_v = v0; end
      default: begin cur_u = u1; cur_v = v1; end
    endcase
  end

  // one shared rounded multiplier for basis and weights
  always_comb begin
    t   = (bstep < 4'd6) ? cur_u : cur_v;
    r   = ONE_Q - t;
    sub = (bstep < 4'd6) ? bstep[2:0] : 3'(bstep - 4'd6);
    if (state == ST_WGT) begin
      mul_a = bu[slot[3:2]];
      mul_b = bv[slot[1:0]];
    end else begin
      case (sub)
        3'd0:    begin mul_a = t;  mul_b = t; end
        3'd1:    begin mul_a = r;  mul_b = r; end
        3'd2:    begin mul_a = r2; mul_b = r; end
        3'd3:    begin mul_a = t;  mul_b = r2; end
        3'd4:    begin mul_a = t2; mul_b = r; end
        default: begin mul_a = t2; mul_b = t; end
      endcase
    end
    mul_full = (mul_a * mul_b) + (2*PARAM_W)'(1 << (FRAC_BITS - 1));
    fx_res   = mul_full[FRAC_BITS +: PARAM_W];
    b_val    = (sub == 3'd3 || sub == 3'd4) ? PARAM_W'(fx_res + {fx_res[PARAM_W-2:0], 1'b0})
                                            : fx_res;
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          if (job.is_emit) state_next = ST_BASIS;
        end
      end
      ST_BASIS: if (bstep == 4'd11) state_next = ST_WGT;
      ST_WGT:   state_next = ST_PROD;
      ST_PROD:  state_next = ST_ACC;
      ST_ACC:   state_next = (slot == 4'd15) ? ST_FIN : ST_WGT;
      ST_FIN: begin
        if (!out_valid) state_next = (vk == 3'd5) ? ST_IDLE : ST_BASIS;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid && !job.is_emit) begin
      coords[job.slot] <= job.coords;
    end
    rd <= coords[slot];
  end

  function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-FRAC_BITS-1:0] q;
    s = a + ACC_W'(1 << (FRAC_BITS - 1));
    q = s[ACC_W-1:FRAC_BITS];
    if (q > (ACC_W-FRAC_BITS)'(32'sh7fffffff)) return 32'sh7fffffff;
    if (q < -(ACC_W-FRAC_BITS)'(33'sh080000000)) return 32'sh80000000;
    return q[31:0];
  endfunction

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        u0 <= job.u0;
        u1 <= job.u1;
        v0 <= job.v0;
        v1 <= job.v1;
        vk <= 3'd0;
        bstep <= 4'd0;
        slot <= 4'd0;
        for (int a = 0; a < 3; a++) acc[a] <= '0;
      end
      ST_BASIS: begin
        bstep <= bstep + 4'd1;
        case (sub)
          3'd0: t2 <= fx_res;
          3'd1: r2 <= fx_res;
          default: begin
            if (bstep < 4'd6) bu[2'(sub - 3'd2)] <= b_val;
            else              bv[2'(sub - 3'd2)] <= b_val;
          end
        endcase
      end
      ST_WGT:  w <= fx_res;
      ST_PROD: begin
        for (int a = 0; a < 3; a++) begin
          prod[a] <= $signed(rd[32*a +: 32]) * $signed({1'b0, w});
        end
      end
      ST_ACC: begin
        slot <= slot + 4'd1;
        for (int a = 0; a < 3; a++) acc[a] <= acc[a] + ACC_W'(prod[a]);
      end
      ST_FIN: begin
        if (!out_valid) begin
          out_item.vert_x      <= round_sat(acc[0]);
          out_item.vert_y      <= round_sat(acc[1]);
          out_item.vert_z      <= round_sat(acc[2]);
          out_item.last_vertex <= (vk == 3'd5);
          vk    <= vk + 3'd1;
          bstep <= 4'd0;
          slot  <= 4'd0;
          for (int a = 0; a < 3; a++) acc[a] <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && !out_valid) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbpt_pkg::*;

  localparam int  HOLD_LEN  = 3000;
  localparam int  CYC_LIMIT = 600000;
  localparam int  DRAIN     = 60;
  localparam longint ONE_T  = 64'd65536;
  localparam int  CELL_TOP  = 255;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        step_we = 1'b0;
  logic [16:0] step_data = '0;

  in_item_t  pend_q[$];
  out_item_t vert_due_q[$];

  logic signed [31:0] ctrl_pt[16][3];
  logic [16:0] step_cur = STEP_RST;

  int send_idle = 0;
  int recv_stall = 0;
  int cyc = 0;
  int hold_from = 32'h7fffffff;
  int n_bad = 0;
  int n_items = 0;
  int n_emits = 0;
  int n_verts = 0;

  bicubic_bezier_patch_tessellator_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .step_we(step_we), .step_data(step_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d vertices pending", cyc, vert_due_q.size());
      $display("bicubic_bezier_patch_tessellator_core: mismatch");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    n_bad++;
    if (n_bad <= 40) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  function automatic longint unsigned rmul(input longint unsigned a, input longint unsigned b);
    return (a * b + 64'd32768) >> 16;
  endfunction

  function automatic longint unsigned edge_t(input int unsigned idx);
    longint unsigned t;
    t = longint'(idx) * longint'(step_cur);
    return (t > ONE_T) ? ONE_T : t;
  endfunction

  function automatic void bern(input longint unsigned t, output longint unsigned b[4]);
    longint unsigned r, r2, t2;
    r = ONE_T - t;
    r2 = rmul(r, r);
    t2 = rmul(t, t);
    b[0] = rmul(r2, r);
    b[1] = 3 * rmul(t, r2);
    b[2] = 3 * rmul(t2, r);
    b[3] = rmul(t2, t);
  endfunction

  function automatic out_item_t surface_at(input longint unsigned u, input longint unsigned v);
    longint unsigned bu[4], bv[4];
    longint acc[3];
    longint w, r;
    logic signed [31:0] res[3];
    out_item_t o;
    bern(u, bu);
    bern(v, bv);
    acc = '{0, 0, 0};
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        w = longint'(rmul(bu[i], bv[j]));
        for (int a = 0; a < 3; a++) acc[a] += longint'(ctrl_pt[i*4+j][a]) * w;
      end
    for (int a = 0; a < 3; a++) begin
      r = (acc[a] + 64'sd32768) >>> 16;  // floor after half-up bias
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res[a] = r[31:0];
    end
    o.vert_x = res[0];
    o.vert_y = res[1];
    o.vert_z = res[2];
    o.last_vertex = 1'b0;
    return o;
  endfunction

  task automatic predict_item(input in_item_t it);
    longint unsigned u0, u1, v0, v1;
    longint unsigned us[6], vs[6];
    out_item_t o;
    if (it.kind == KIND_LOAD) begin
      ctrl_pt[it.slot][0] = it.point_x;
      ctrl_pt[it.slot][1] = it.point_y;
      ctrl_pt[it.slot][2] = it.point_z;
      return;
    end
    n_emits++;
    u0 = edge_t(it.cell_u);
    u1 = edge_t(it.cell_u + 1);
    v0 = edge_t(it.cell_v);
    v1 = edge_t(it.cell_v + 1);
    us = '{u0, u1, u0, u0, u1, u1};
    vs = '{v0, v0, v1, v1, v0, v1};
    for (int k = 0; k < 6; k++) begin
      o = surface_at(us[k], vs[k]);
      o.last_vertex = (k == 5);
      vert_due_q.push_back(o);
    end
  endtask

  // input side: accept and predict
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      if (pend_q.size() == 0) flag_mismatch("accept with nothing offered");
      else begin
        predict_item(pend_q.pop_front());
        n_items++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) push <= 1'b0;
    else if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
      push <= 1'b1;
      in_item <= pend_q[0];
    end else push <= 1'b0;
  end

  // receiver, with one long hold-off window
  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else if (cyc >= hold_from && cyc < hold_from + HOLD_LEN) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_stall);
  end

  // output check
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && pop && !empty) begin
      if (vert_due_q.size() == 0) flag_mismatch("vertex with none expected");
      else begin
        e = vert_due_q.pop_front();
        n_verts++;
        if (out_item.vert_x !== e.vert_x)
          flag_mismatch($sformatf("vert_x %h exp %h", out_item.vert_x, e.vert_x));
        if (out_item.vert_y !== e.vert_y)
          flag_mismatch($sformatf("vert_y %h exp %h", out_item.vert_y, e.vert_y));
        if (out_item.vert_z !== e.vert_z)
          flag_mismatch($sformatf("vert_z %h exp %h", out_item.vert_z, e.vert_z));
        if (out_item.last_vertex !== e.last_vertex)
          flag_mismatch($sformatf("last_vertex %b exp %b", out_item.last_vertex,
                                  e.last_vertex));
      end
    end
  end

  function automatic in_item_t mk_load(input logic [3:0] s, input logic [31:0] x,
                                       input logic [31:0] y, input logic [31:0] z);
    in_item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.slot = s;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.cell_u = 8'($urandom);
    it.cell_v = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_emit(input logic [7:0] cu, input logic [7:0] cv);
    in_item_t it;
    it.kind = KIND_EMIT;
    it.slot = 4'($urandom);
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.point_z = $urandom;
    it.cell_u = cu;
    it.cell_v = cv;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(32'h000fffff);
      default: return $urandom;
    endcase
  endfunction

  // waits for the block to go quiet, then writes the step
  task automatic set_step(input logic [16:0] s);
    wait (pend_q.size() == 0 && vert_due_q.size() == 0);
    repeat (DRAIN) @(negedge clk);
    step_we <= 1'b1;
    step_data <= s;
    @(negedge clk);
    step_we <= 1'b0;
    step_cur = s;
  endtask

  task automatic random_items(input int n);
    int span;
    span = (step_cur == 0) ? CELL_TOP : ((65536 / step_cur) > CELL_TOP ? CELL_TOP
                                                                    : 65536 / step_cur);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 18)
        pend_q.push_back(mk_load(4'($urandom), rand_coord(), rand_coord(), rand_coord()));
      else if ($urandom_range(99) < 85)
        pend_q.push_back(mk_emit(8'($urandom_range(span)), 8'($urandom_range(span))));
      else
        pend_q.push_back(mk_emit(8'($urandom), 8'($urandom)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_step(STEP_RST);

    // directed: full patch at positive extreme, then negative in x and y, then random
    for (int s = 0; s < 16; s++)
      pend_q.push_back(mk_load(4'(s), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pend_q.push_back(mk_emit(8'd0, 8'd0));
    pend_q.push_back(mk_emit(8'd3, 8'd3));
    for (int s = 0; s < 16; s++) begin
      pend_q.push_back(mk_load(4'(s), 32'h80000000, 32'h80000000, $urandom));
      if (s == 15) pend_q.push_back(mk_emit(8'd1, 8'd2));
    end
    pend_q.push_back(mk_emit(8'd255, 8'd255));  // clamps to the patch edge
    pend_q.push_back(mk_emit(8'd2, 8'd200));
    for (int s = 0; s < 16; s++)
      pend_q.push_back(mk_load(4'(s), rand_coord(), rand_coord(), rand_coord()));
    pend_q.push_back(mk_emit(8'd1, 8'd0));

    set_step(17'd1);
    send_idle = 65;
    random_items(8);

    set_step(17'd65536);
    send_idle = 0;
    recv_stall = 65;
    hold_from = cyc + 10;
    random_items(14);

    set_step(17'd0);  // every vertex collapses to the origin corner
    send_idle = 22;
    recv_stall = 22;
    random_items(8);

    set_step(17'h1ffff);  // beyond 1.0, saturates
    send_idle = 0;
    recv_stall = 0;
    random_items(8);

    set_step(17'd5461);
    send_idle = 22;
    recv_stall = 22;
    random_items(10);

    set_step(17'd21845);
    send_idle = 0;
    recv_stall = 65;
    random_items(8);

    wait (pend_q.size() == 0 && vert_due_q.size() == 0);
    repeat (DRAIN * 8) @(posedge clk);
    $display("covered %0d items (%0d cell emits), %0d vertices checked,", n_items, n_emits,
             n_verts);
    $display("seven step settings incl. 0, 1, 1.0 and oversized, with idle and long stall");
    if (n_bad == 0 && vert_due_q.size() == 0)
      $display("bicubic_bezier_patch_tessellator_core: match");
    else
      $display("bicubic_bezier_patch_tessellator_core: mismatch");
    $finish;
  end
endmodule

@@ files.f @@
sv/bbpt_pkg.sv
sv/bbpt_front.sv
sv/bbpt_back.sv
sv/bicubic_bezier_patch_tessellator_core.sv
tb/tb.sv
